// ----- sv/piecewise_linear_spike_kernel_core_macros.svh -----
// Assertion macros for the spike kernel checkers
`ifndef PIECEWISE_LINEAR_SPIKE_KERNEL_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_SPIKE_KERNEL_CORE_MACROS_SVH

// Condition and consequence in the same cycle
`define PLSK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plsk check failed");

// Condition, then consequence in the next cycle
`define PLSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plsk check failed");

`endif

// ----- sv/plsk_pkg.sv -----
`timescale 1ns / 1ps
package plsk_pkg;

   // Sizes
   localparam int unsigned MAX_POINTS   = 3;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned DELAY_W      = 16;
   localparam int unsigned INDEX_W      = 2;
   localparam int unsigned CMD_W        = 2;
   localparam int unsigned SERIAL_STEPS = 32;
   localparam int unsigned STEP_CNT_W   = 6;
   localparam int unsigned PROD_W       = 35;
   localparam int unsigned CSR_ADDR_W   = 5;
   localparam int unsigned REG_IDX_W    = 3;
   localparam int unsigned RSP_FIELDS_W = 98;
   localparam int unsigned RSP_TDATA_W  = 104;

   // Command codes; anything else acts as an update
   localparam logic [CMD_W-1:0] CMD_SPIKE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_AMP_0       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_AMP_1       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_AMP_2       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_0     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_1     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_2     = 3'd6;

   // Saturation bounds
   localparam logic [DATA_W-1:0] MAX_POS  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_NEG  = 32'h8000_0000;
   localparam logic [PROD_W-1:0] PROD_CAP = 35'h2_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               start;
      logic               neg;
      logic [DATA_W-1:0]  mag;
      logic [DELAY_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] ticks;
      logic [DATA_W-1:0] rate;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

// ----- sv/plsk_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider: 32-bit magnitude by 16-bit divisor, one quotient
// bit per cycle, result signed and saturated to 32 bits.
module plsk_div (
   input  logic                  clock,
   input  logic                  reset,
   input  plsk_pkg::div_req_type div_req,
   output plsk_pkg::div_rsp_type div_rsp
);

   logic [plsk_pkg::DELAY_W-1:0]    rem_ff, rem_in;
   logic [plsk_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [plsk_pkg::DELAY_W-1:0]    dvs_ff, dvs_in;
   logic                            neg_ff, neg_in;
   logic [plsk_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            done_ff, done_in;
   logic [plsk_pkg::DELAY_W:0]      part;
   logic [plsk_pkg::DELAY_W:0]      trial;
   logic                            fits;

   // One restoring step: bring in the next dividend bit, try to subtract
   always_comb begin
      part  = {rem_ff, quo_ff[plsk_pkg::DATA_W-1]};
      trial = part - {1'b0, dvs_ff};
      fits  = (part >= {1'b0, dvs_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      priority if (div_req.start) begin
         rem_in = '0;
         quo_in = div_req.mag;
         dvs_in = div_req.divisor;
         neg_in = div_req.neg;
         cnt_in = plsk_pkg::STEP_CNT_W'(plsk_pkg::SERIAL_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? trial[plsk_pkg::DELAY_W-1:0] : part[plsk_pkg::DELAY_W-1:0];
         quo_in  = {quo_ff[plsk_pkg::DATA_W-2:0], fits};
         cnt_in  = cnt_ff - plsk_pkg::STEP_CNT_W'(1);
         done_in = (cnt_ff == plsk_pkg::STEP_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // Apply sign and clamp to the signed 32-bit range
   always_comb begin
      div_rsp.done = done_ff;
      priority if (!neg_ff) begin
         div_rsp.quotient = quo_ff[plsk_pkg::DATA_W-1] ? plsk_pkg::MAX_POS : quo_ff;
      end else if (quo_ff > plsk_pkg::MIN_NEG) begin
         div_rsp.quotient = plsk_pkg::MIN_NEG;
      end else begin
         div_rsp.quotient = '0 - quo_ff;
      end
   end

endmodule

// ----- sv/plsk_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: elapsed ticks times signed slope, one tick
// bit per cycle from the top, magnitude clamped at 2^33 along the way.
module plsk_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  plsk_pkg::mul_req_type mul_req,
   output plsk_pkg::mul_rsp_type mul_rsp
);

   logic [plsk_pkg::DATA_W-1:0]     ticks_ff, ticks_in;
   logic [plsk_pkg::DATA_W-1:0]     mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [plsk_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [plsk_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            done_ff, done_in;
   logic [plsk_pkg::PROD_W-1:0]     sum;

   // Double and add; acc never exceeds the cap, so the top bit is free
   always_comb begin
      sum = {acc_ff[plsk_pkg::PROD_W-2:0], 1'b0}
          + (ticks_ff[plsk_pkg::DATA_W-1] ? {3'b000, mag_ff} : '0);
   end

   always_comb begin
      ticks_in = ticks_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      priority if (mul_req.start) begin
         ticks_in = mul_req.ticks;
         neg_in   = mul_req.rate[plsk_pkg::DATA_W-1];
         mag_in   = mul_req.rate[plsk_pkg::DATA_W-1] ? ('0 - mul_req.rate) : mul_req.rate;
         acc_in   = '0;
         cnt_in   = plsk_pkg::STEP_CNT_W'(plsk_pkg::SERIAL_STEPS);
      end else if (cnt_ff != '0) begin
         ticks_in = {ticks_ff[plsk_pkg::DATA_W-2:0], 1'b0};
         acc_in   = (sum > plsk_pkg::PROD_CAP) ? plsk_pkg::PROD_CAP : sum;
         cnt_in   = cnt_ff - plsk_pkg::STEP_CNT_W'(1);
         done_in  = (cnt_ff == plsk_pkg::STEP_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff <= ticks_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      mul_rsp.done    = done_ff;
      mul_rsp.product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
   end

endmodule

// ----- sv/piecewise_linear_spike_kernel_core.sv -----
// Flow: IDLE captures a req beat, DECODE decodes it and goes to EMIT unless a slope
//   division (DIV) or a linear integration (MUL) runs on the bit-serial units.
// Throughput: one item in flight; the next req beat is taken once the result is
//   registered in EMIT and the core is back in IDLE; rsp back-pressure holds EMIT.
// Reset: synchronous, active high; clears control, configuration and kernel state (next
//   event all ones) and rsp_tvalid; payload registers are not reset.
`timescale 1ns / 1ps
module piecewise_linear_spike_kernel_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [plsk_pkg::DATA_W-1:0]            req_tdata,   // [31:0] event_time
   input  logic [plsk_pkg::CMD_W-1:0]             req_tuser,   // [1:0] command
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [31:0] response, [63:32] previous_response, [64] scheduled,
   // [96:65] next_time, [97] active, [103:98] zero
   output logic [plsk_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [plsk_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [plsk_pkg::DATA_W-1:0]            csr_pwdata,
   output logic [plsk_pkg::DATA_W-1:0]            csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned DW = plsk_pkg::DATA_W;
   localparam int unsigned LW = plsk_pkg::DELAY_W;
   localparam int unsigned IW = plsk_pkg::INDEX_W;

   // Configuration registers
   logic [IW-1:0] count_ff, count_in;
   logic [DW-1:0] amp_ff   [plsk_pkg::MAX_POINTS];
   logic [DW-1:0] amp_in   [plsk_pkg::MAX_POINTS];
   logic [LW-1:0] delay_ff [plsk_pkg::MAX_POINTS];
   logic [LW-1:0] delay_in [plsk_pkg::MAX_POINTS];

   // Kernel state
   logic [IW-1:0] point_index_ff, point_index_in;
   logic          is_active_ff, is_active_in;
   logic [DW-1:0] level_ff, level_in;
   logic [DW-1:0] rate_ff, rate_in;
   logic [DW-1:0] last_time_ff, last_time_in;
   logic [DW-1:0] expected_time_ff, expected_time_in;

   // Item in flight
   plsk_pkg::state_type state_ff, state_in;
   logic [plsk_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [DW-1:0] time_ff, time_in;
   logic [DW-1:0] prev_ff, prev_in;
   logic          sched_ff, sched_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plsk_pkg::RSP_FIELDS_W-1:0] rsp_data_ff, rsp_data_in;

   // Serial units
   plsk_pkg::div_req_type div_req;
   plsk_pkg::div_rsp_type div_rsp;
   plsk_pkg::mul_req_type mul_req;
   plsk_pkg::mul_rsp_type mul_rsp;

   // Decode terms
   logic                 cfg_wr;
   logic [plsk_pkg::REG_IDX_W-1:0] cfg_idx;
   logic [IW-1:0]        count_eff;
   logic                 restart;
   logic [IW-1:0]        idx;
   logic                 go_idle;
   logic [LW-1:0]        dl;
   logic [DW-1:0]        amp_cur;
   logic [DW-1:0]        amp_next;
   logic                 slope_need;
   logic [DW:0]          diff;
   logic [DW:0]          diff_abs;
   logic [DW:0]          next_sum;
   logic                 do_int;
   logic signed [DW+3:0] level_sum;
   logic                 out_free;

   function automatic logic [DW-1:0] sat_level(input logic signed [DW+3:0] v);
      logic [DW-1:0] r;
      priority if (v > $signed({4'b0000, plsk_pkg::MAX_POS})) begin
         r = plsk_pkg::MAX_POS;
      end else if (v < $signed({4'b1111, plsk_pkg::MIN_NEG})) begin
         r = plsk_pkg::MIN_NEG;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   plsk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   plsk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Configuration write decode
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx    = csr_paddr[plsk_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      count_in = count_ff;
      amp_in   = amp_ff;
      delay_in = delay_ff;
      if (cfg_wr) begin
         unique case (cfg_idx)
            plsk_pkg::REG_POINT_COUNT: count_in    = csr_pwdata[IW-1:0];
            plsk_pkg::REG_AMP_0:       amp_in[0]   = csr_pwdata;
            plsk_pkg::REG_AMP_1:       amp_in[1]   = csr_pwdata;
            plsk_pkg::REG_AMP_2:       amp_in[2]   = csr_pwdata;
            plsk_pkg::REG_DELAY_0:     delay_in[0] = csr_pwdata[LW-1:0];
            plsk_pkg::REG_DELAY_1:     delay_in[1] = csr_pwdata[LW-1:0];
            plsk_pkg::REG_DELAY_2:     delay_in[2] = csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (cfg_idx)
         plsk_pkg::REG_POINT_COUNT: csr_prdata = {{(DW-IW){1'b0}}, count_ff};
         plsk_pkg::REG_AMP_0:       csr_prdata = amp_ff[0];
         plsk_pkg::REG_AMP_1:       csr_prdata = amp_ff[1];
         plsk_pkg::REG_AMP_2:       csr_prdata = amp_ff[2];
         plsk_pkg::REG_DELAY_0:     csr_prdata = {{(DW-LW){1'b0}}, delay_ff[0]};
         plsk_pkg::REG_DELAY_1:     csr_prdata = {{(DW-LW){1'b0}}, delay_ff[1]};
         plsk_pkg::REG_DELAY_2:     csr_prdata = {{(DW-LW){1'b0}}, delay_ff[2]};
         default:                   csr_prdata = '0;
      endcase
   end

   // Command decode on the held item
   always_comb begin
      count_eff = (count_ff > IW'(plsk_pkg::MAX_POINTS)) ? IW'(plsk_pkg::MAX_POINTS)
                                                         : count_ff;
      restart   = (cmd_ff == plsk_pkg::CMD_SPIKE)
                | ((cmd_ff == plsk_pkg::CMD_EVENT) & is_active_ff
                   & (time_ff == expected_time_ff));
      idx       = (cmd_ff == plsk_pkg::CMD_SPIKE) ? '0 : point_index_ff + IW'(1);
      go_idle   = (idx >= count_eff);
      unique case (idx)
         2'd0:    begin dl = delay_ff[0]; amp_cur = amp_ff[0]; amp_next = amp_ff[1]; end
         2'd1:    begin dl = delay_ff[1]; amp_cur = amp_ff[1]; amp_next = amp_ff[2]; end
         2'd2:    begin dl = delay_ff[2]; amp_cur = amp_ff[2]; amp_next = '0;        end
         default: begin dl = '0;          amp_cur = '0;        amp_next = '0;        end
      endcase
      slope_need = !go_idle && (({1'b0, idx} + 3'd1) < {1'b0, count_eff}) && (dl != '0);
      diff       = {amp_next[DW-1], amp_next} - {amp_cur[DW-1], amp_cur};
      diff_abs   = diff[DW] ? ('0 - diff) : diff;
      next_sum   = {1'b0, time_ff} + {{(DW-LW+1){1'b0}}, dl};
      do_int     = (time_ff > last_time_ff);
      level_sum  = $signed({{4{level_ff[DW-1]}}, level_ff})
                 + $signed({mul_rsp.product[plsk_pkg::PROD_W-1], mul_rsp.product});
      out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plsk_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = plsk_pkg::ST_DECODE;
         end
         plsk_pkg::ST_DECODE: begin
            priority if (restart && slope_need) state_in = plsk_pkg::ST_DIV;
            else if (!restart && do_int)        state_in = plsk_pkg::ST_MUL;
            else                                state_in = plsk_pkg::ST_EMIT;
         end
         plsk_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = plsk_pkg::ST_EMIT;
         end
         plsk_pkg::ST_MUL: begin
            if (mul_rsp.done) state_in = plsk_pkg::ST_EMIT;
         end
         plsk_pkg::ST_EMIT: begin
            if (out_free) state_in = plsk_pkg::ST_IDLE;
         end
         default: state_in = plsk_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      point_index_in   = point_index_ff;
      is_active_in     = is_active_ff;
      level_in         = level_ff;
      rate_in          = rate_ff;
      last_time_in     = last_time_ff;
      expected_time_in = expected_time_ff;
      cmd_in           = cmd_ff;
      time_in          = time_ff;
      prev_in          = prev_ff;
      sched_in         = sched_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      req_tready       = (state_ff == plsk_pkg::ST_IDLE);

      div_req.start    = 1'b0;
      div_req.neg      = diff[DW];
      div_req.mag      = diff_abs[DW-1:0];
      div_req.divisor  = dl;
      mul_req.start    = 1'b0;
      mul_req.ticks    = time_ff - last_time_ff;
      mul_req.rate     = rate_ff;

      unique case (state_ff)
         plsk_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               time_in = req_tdata;
            end
         end
         plsk_pkg::ST_DECODE: begin
            prev_in  = level_ff;
            sched_in = 1'b0;
            if (restart) begin
               last_time_in = time_ff;
               rate_in      = '0;
               if (go_idle) begin
                  is_active_in     = 1'b0;
                  point_index_in   = '0;
                  level_in         = '0;
                  expected_time_in = '1;
               end else begin
                  is_active_in     = 1'b1;
                  point_index_in   = idx;
                  level_in         = amp_cur;
                  expected_time_in = next_sum[DW] ? '1 : next_sum[DW-1:0];
                  sched_in         = 1'b1;
                  div_req.start    = slope_need;
               end
            end else begin
               mul_req.start = do_int;
            end
         end
         plsk_pkg::ST_DIV: begin
            if (div_rsp.done) rate_in = div_rsp.quotient;
         end
         plsk_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               level_in     = sat_level(level_sum);
               last_time_in = time_ff;
            end
         end
         plsk_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {is_active_ff, expected_time_ff, sched_ff, prev_ff, level_ff};
            end
         end
         default: ;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= plsk_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         count_ff         <= '0;
         amp_ff           <= '{default: '0};
         delay_ff         <= '{default: '0};
         point_index_ff   <= '0;
         is_active_ff     <= 1'b0;
         level_ff         <= '0;
         rate_ff          <= '0;
         last_time_ff     <= '0;
         expected_time_ff <= '1;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         count_ff         <= count_in;
         amp_ff           <= amp_in;
         delay_ff         <= delay_in;
         point_index_ff   <= point_index_in;
         is_active_ff     <= is_active_in;
         level_ff         <= level_in;
         rate_ff          <= rate_in;
         last_time_ff     <= last_time_in;
         expected_time_ff <= expected_time_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      time_ff     <= time_in;
      prev_ff     <= prev_in;
      sched_ff    <= sched_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(plsk_pkg::RSP_TDATA_W - plsk_pkg::RSP_FIELDS_W){1'b0}}, rsp_data_ff};

endmodule

// ----- sv/plsk_checker.sv -----
`timescale 1ns / 1ps
`include "piecewise_linear_spike_kernel_core_macros.svh"
module plsk_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [plsk_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              csr_psel,
   input logic                              csr_pready
);

   logic rsp_wait;
   logic req_beat;
   logic rsp_idle;
   logic idle_fields_ok;

   // Handshake and field terms
   assign rsp_wait       = rsp_tvalid && !rsp_tready;
   assign req_beat       = req_tvalid && req_tready;
   assign rsp_idle       = rsp_tvalid && !rsp_tdata[97];
   assign idle_fields_ok = (rsp_tdata[31:0] == 32'h0) && (rsp_tdata[96:65] == 32'hFFFF_FFFF)
                         && !rsp_tdata[64];

   // A stalled result beat holds
   `PLSK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))

   // One item at a time: after a req beat the input side closes
   `PLSK_ASSERT_NEXT(a_one_item, clock, reset, req_beat, !req_tready)

   // An inactive kernel reports zero response and no pending event
   `PLSK_ASSERT_SAME(a_idle_zero, clock, reset, rsp_idle, idle_fields_ok)

   // Config port never waits
   `PLSK_ASSERT_SAME(a_pready, clock, reset, csr_psel, csr_pready)

endmodule

bind piecewise_linear_spike_kernel_core plsk_checker u_plsk_checker (.*);
